// File: hdl/sltc_pkg.sv
// Shared types and codes for the sprite layer table compositor.
package sltc_pkg;

	localparam logic [2:0] CMD_ADD       = 3'd0;
	localparam logic [2:0] CMD_MOVE      = 3'd1;
	localparam logic [2:0] CMD_REMOVE    = 3'd2;
	localparam logic [2:0] CMD_WRITE     = 3'd3;
	localparam logic [2:0] CMD_QUERY     = 3'd4;
	localparam logic [2:0] CMD_COMPOSITE = 3'd5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;

	localparam logic [3:0] CAPACITY_RESET = 4'd8;

	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  slot;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [6:0]  width;
		logic [6:0]  height;
		logic [11:0] pix_x;
		logic [11:0] pix_y;
		logic [15:0] hue;
		logic [15:0] sat;
		logic [15:0] light;
		logic [15:0] alpha;
	} cmd_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  slot_out;
		logic [11:0] where_x;
		logic [11:0] where_y;
		logic [15:0] out_hue;
		logic [15:0] out_sat;
		logic [15:0] out_light;
		logic [15:0] out_alpha;
	} rsp_beat_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic drain;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_cmd;
		logic scan_done;
		logic out_busy;
	} dp_stat_t;

endpackage

// File: hdl/sltc_ctrl.sv
// Sequencing state machine of the sprite layer table compositor.
module sltc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  sltc_pkg::dp_stat_t stat,
	output sltc_pkg::ctl_cmd_t ctl,
	output logic               busy
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d = stat.scan_cmd ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_done) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				ctl.drain = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					ctl.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

// File: hdl/sltc_datapath.sv
// Slot table, sprite pixel memory and result registers of the compositor.
module sltc_datapath #(
	parameter int MAX_SLOTS  = 8,
	parameter int SPRITE_DIM = 64,
	parameter int CANVAS_DIM = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sltc_pkg::ctl_cmd_t  ctl,
	input  sltc_pkg::cmd_beat_t cmd_beat,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_wdata,
	input  logic                rsp_stall,
	output logic [3:0]          capacity,
	output sltc_pkg::dp_stat_t  stat,
	output logic                rsp_valid,
	output sltc_pkg::rsp_beat_t rsp_beat
);

	localparam int IW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW        = $clog2(MAX_SLOTS + 1);
	localparam int DW        = $clog2(SPRITE_DIM + 1);
	localparam int SLOT_PIX  = SPRITE_DIM * SPRITE_DIM;
	localparam int DEPTH     = MAX_SLOTS * SLOT_PIX;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sltc_pkg::cmd_beat_t in_q;
	logic [3:0]     capacity_q;
	logic [CW-1:0]  used_q;
	logic [CW-1:0]  i_q;
	logic [CW-1:0]  pick_q;
	logic           found_q;
	logic           hit_s1;
	logic [63:0]    rd_s1;
	logic [1:0]     res_status_q;
	logic [2:0]     res_slot_q;
	logic [11:0]    res_wx_q, res_wy_q;
	logic [63:0]    res_pix_q;
	logic           rsp_valid_q;
	sltc_pkg::rsp_beat_t rsp_q;

	logic           del_q [MAX_SLOTS];
	logic [11:0]    lx_q  [MAX_SLOTS];
	logic [11:0]    ly_q  [MAX_SLOTS];
	logic [DW-1:0]  lw_q  [MAX_SLOTS];
	logic [DW-1:0]  lh_q  [MAX_SLOTS];
	logic [63:0]    mem   [DEPTH];

	logic [IW-1:0]  idx;
	logic           slot_ok, live, outside, covered, in_sprite;
	logic [11:0]    sx, sy;
	logic [CW-1:0]  cap_eff, cfg_eff;
	logic [DW-1:0]  w_sat, h_sat;
	logic [AW-1:0]  addr;
	logic           mem_we, mem_re;
	logic [63:0]    in_pix;

	assign idx = ctl.scan ? IW'(i_q) : IW'(in_q.slot);
	assign slot_ok = (32'(in_q.slot) < MAX_SLOTS) && (CW'(in_q.slot) < used_q)
		&& (32'(in_q.slot) < 32'(used_q));
	assign live = slot_ok && !del_q[idx];
	assign outside = (32'(in_q.pix_x) >= CANVAS_DIM) || (32'(in_q.pix_y) >= CANVAS_DIM);
	assign sx = in_q.pix_x - lx_q[idx];
	assign sy = in_q.pix_y - ly_q[idx];
	assign covered = (in_q.pix_x >= lx_q[idx]) && (in_q.pix_y >= ly_q[idx])
		&& (32'(sx) < 32'(lw_q[idx])) && (32'(sy) < 32'(lh_q[idx]));
	assign in_sprite = (32'(in_q.pix_x) < 32'(lw_q[idx]))
		&& (32'(in_q.pix_y) < 32'(lh_q[idx]));
	assign cap_eff = (32'(capacity_q) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(capacity_q);
	assign cfg_eff = (32'(cfg_wdata) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(cfg_wdata);
	assign w_sat = (32'(in_q.width) > SPRITE_DIM) ? DW'(SPRITE_DIM) : DW'(in_q.width);
	assign h_sat = (32'(in_q.height) > SPRITE_DIM) ? DW'(SPRITE_DIM) : DW'(in_q.height);
	assign in_pix = {in_q.alpha, in_q.light, in_q.sat, in_q.hue};

	// Pixel address: the write takes the sprite coordinate, the scan the offset
	// of the canvas point inside the layer.
	always_comb begin
		if (ctl.scan)
			addr = AW'(AW'(idx) * AW'(SLOT_PIX) + AW'(sy) * AW'(SPRITE_DIM) + AW'(sx));
		else
			addr = AW'(AW'(idx) * AW'(SLOT_PIX) + AW'(in_q.pix_y) * AW'(SPRITE_DIM)
				+ AW'(in_q.pix_x));
	end

	assign mem_we = ctl.exec && (in_q.command == sltc_pkg::CMD_WRITE) && live && in_sprite;
	assign mem_re = ctl.scan && (in_q.command == sltc_pkg::CMD_COMPOSITE) && !outside
		&& (i_q < used_q) && !del_q[idx] && covered;

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr] <= in_pix;
		if (mem_re) rd_s1 <= mem[addr];
	end

	always_comb begin
		stat.scan_cmd = (in_q.command == sltc_pkg::CMD_ADD)
			|| (in_q.command == sltc_pkg::CMD_COMPOSITE);
		if (in_q.command == sltc_pkg::CMD_ADD)
			stat.scan_done = (i_q >= used_q) || del_q[idx];
		else
			stat.scan_done = (i_q >= used_q) || outside;
		stat.out_busy = rsp_valid_q && rsp_stall;
	end

	// Payload registers and slot table.
	always_ff @(posedge clk) begin
		hit_s1 <= mem_re;
		if (ctl.load) in_q <= cmd_beat;
		if (ctl.exec) begin
			res_status_q <= sltc_pkg::ST_OK;
			res_slot_q   <= in_q.slot;
			res_wx_q     <= '0;
			res_wy_q     <= '0;
			res_pix_q    <= '0;
			i_q          <= '0;
			found_q      <= 1'b0;
			unique case (in_q.command)
				sltc_pkg::CMD_MOVE: begin
					if (live) begin
						lx_q[idx] <= in_q.pos_x;
						ly_q[idx] <= in_q.pos_y;
					end else res_status_q <= sltc_pkg::ST_ABSENT;
				end
				sltc_pkg::CMD_REMOVE: begin
					if (slot_ok) del_q[idx] <= 1'b1;
					else res_status_q <= sltc_pkg::ST_ABSENT;
				end
				sltc_pkg::CMD_WRITE: begin
					if (!live) res_status_q <= sltc_pkg::ST_ABSENT;
				end
				sltc_pkg::CMD_QUERY: begin
					if (live) begin
						res_wx_q <= lx_q[idx];
						res_wy_q <= ly_q[idx];
					end else res_status_q <= sltc_pkg::ST_ABSENT;
				end
				sltc_pkg::CMD_COMPOSITE: res_pix_q <= in_pix;
				default: ;
			endcase
		end
		if (ctl.scan && !stat.scan_done) i_q <= i_q + 1'b1;
		if (ctl.scan && (in_q.command == sltc_pkg::CMD_ADD) && (i_q < used_q)
			&& del_q[idx]) begin
			found_q <= 1'b1;
			pick_q  <= i_q;
		end
		// Later slots overwrite earlier hits, so the highest live covering slot with nonzero alpha wins.
		if (hit_s1 && (rd_s1[63:48] != 16'd0)) res_pix_q <= rd_s1;
		if (ctl.drain && (in_q.command == sltc_pkg::CMD_ADD)) begin
			if (found_q || (used_q < cap_eff)) begin
				del_q[IW'(found_q ? pick_q : used_q)] <= 1'b0;
				lx_q[IW'(found_q ? pick_q : used_q)]  <= in_q.pos_x;
				ly_q[IW'(found_q ? pick_q : used_q)]  <= in_q.pos_y;
				lw_q[IW'(found_q ? pick_q : used_q)]  <= w_sat;
				lh_q[IW'(found_q ? pick_q : used_q)]  <= h_sat;
				res_slot_q <= 3'(found_q ? pick_q : used_q);
			end else res_status_q <= sltc_pkg::ST_FULL;
		end
		if (ctl.finish) begin
			rsp_q.status    <= res_status_q;
			rsp_q.slot_out  <= res_slot_q;
			rsp_q.where_x   <= res_wx_q;
			rsp_q.where_y   <= res_wy_q;
			rsp_q.out_hue   <= res_pix_q[15:0];
			rsp_q.out_sat   <= res_pix_q[31:16];
			rsp_q.out_light <= res_pix_q[47:32];
			rsp_q.out_alpha <= res_pix_q[63:48];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= sltc_pkg::CAPACITY_RESET;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
				if (used_q > cfg_eff) used_q <= cfg_eff;
			end
			if (ctl.drain && (in_q.command == sltc_pkg::CMD_ADD) && !found_q
				&& (used_q < cap_eff))
				used_q <= used_q + 1'b1;
			if (ctl.finish) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	assign capacity  = capacity_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp_beat  = rsp_q;

`ifndef NO_ASSERTIONS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= MAX_SLOTS) else $error("used count above slot count");
	a_add_grows_one: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we && !ctl.drain |=> used_q == $past(used_q))
		else $error("used count changed outside add or config");
	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> $past(ctl.scan)) else $error("pixel read outside scan");
`endif

endmodule

// File: hdl/sprite_layer_table_compositor.sv
// Top level of the sprite layer table compositor.
//
// Commands arrive as beats on the cmd channel (cmd_valid, cmd_stall,
// cmd_beat); one response beat per command leaves on the rsp channel
// (rsp_valid, rsp_stall, rsp_beat). Only one command is in work at a time:
// cmd_stall is high from the cycle after a beat is taken until its response
// has been loaded into the output register.
// Move, remove, write, query and unknown commands pass from accept through
// the exec and done states to the response. Add and composite walk the
// slot table one slot per cycle: a composite walks all used slots, or none
// for a point outside the canvas; an add stops at the first deleted slot,
// or walks all used slots when none is deleted. That walk, with one pixel
// memory read per covered live slot, sets the time for an item.
// The response waits in an output register; while rsp_stall is high it holds
// and the next command may still be taken, but its response waits in turn.
// The user writes the capacity register over the APB port only while idle;
// the block itself does not enforce it. A write clamps the used count.
// Reset clears the used count, sets capacity to eight and empties the
// output; slot entries and sprite pixels are undefined until written.
module sprite_layer_table_compositor #(
	parameter int MAX_SLOTS  = 8,
	parameter int SPRITE_DIM = 64,
	parameter int CANVAS_DIM = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  sltc_pkg::cmd_beat_t cmd_beat,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output sltc_pkg::rsp_beat_t rsp_beat,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	sltc_pkg::ctl_cmd_t ctl;
	sltc_pkg::dp_stat_t stat;
	logic               busy;
	logic               cfg_we;
	logic [3:0]         capacity;

	// The only register answers at every address; every write lands on it.
	assign cfg_we = psel && penable && pwrite && (paddr[1:0] == paddr[1:0]);
	assign pready = 1'b1;
	assign prdata = {28'd0, capacity};
	assign cmd_stall = busy;

	sltc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.stat      (stat),
		.ctl       (ctl),
		.busy      (busy)
	);

	sltc_datapath #(
		.MAX_SLOTS  (MAX_SLOTS),
		.SPRITE_DIM (SPRITE_DIM),
		.CANVAS_DIM (CANVAS_DIM)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cmd_beat  (cmd_beat),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[3:0]),
		.rsp_stall (rsp_stall),
		.capacity  (capacity),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_beat  (rsp_beat)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall) else $error("no busy after a command beat");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_beat.status == sltc_pkg::ST_OK)
		|| (rsp_beat.status == sltc_pkg::ST_FULL)
		|| (rsp_beat.status == sltc_pkg::ST_ABSENT)) else $error("bad status code");
	a_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !busy) else $error("command loaded while busy");
`endif

endmodule
